FILE: rtl/shp_pkg.sv
// Shared types, constants and the per-channel sharpen function of the 3x3 sharpen filter.
// Used by every module under rtl; depends on nothing else.
`default_nettype none
package shp_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned WCFG_W = COL_W + 1;
  localparam int unsigned HCFG_W = ROW_W + 1;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned PIX_W  = 3 * CH_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = HCFG_W;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [WCFG_W-1:0] WIDTH_RESET  = WCFG_W'(640);
  localparam logic [HCFG_W-1:0] HEIGHT_RESET = HCFG_W'(480);
  localparam logic [WCFG_W-1:0] WIDTH_MIN    = WCFG_W'(3);
  localparam logic [WCFG_W-1:0] WIDTH_MAX    = WCFG_W'(MAX_WIDTH);
  localparam logic [HCFG_W-1:0] HEIGHT_MIN   = HCFG_W'(3);
  localparam logic [HCFG_W-1:0] HEIGHT_MAX   = HCFG_W'(MAX_HEIGHT);

  // Result kinds of one input item, in emission order.
  localparam int unsigned KIND_CENTER = 0;
  localparam int unsigned KIND_RIGHT  = 1;
  localparam int unsigned KIND_BOTTOM = 2;
  localparam int unsigned KIND_CORNER = 3;
  localparam int unsigned KIND_N      = 4;

  localparam int unsigned OUT_FIELDS_W = ROW_W + COL_W + PIX_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic [KIND_N-1:0] kinds;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [PIX_W-1:0]  pix;
  } res_t;

  function automatic logic [CH_W-1:0] sharpen_ch(input logic [CH_W-1:0] c,
                                                 input logic [CH_W-1:0] u,
                                                 input logic [CH_W-1:0] d,
                                                 input logic [CH_W-1:0] l,
                                                 input logic [CH_W-1:0] r);
    logic signed [CH_W+3:0] v;
    logic [CH_W-1:0]        res;
    v = ($signed({4'd0, c}) <<< 2) + $signed({4'd0, c})
        - $signed({4'd0, u}) - $signed({4'd0, d})
        - $signed({4'd0, l}) - $signed({4'd0, r});
    if (v < 0) begin
      res = '0;
    end else if (v > $signed((CH_W+4)'(255))) begin
      res = '1;
    end else begin
      res = v[CH_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sharpen_3x3_line_buffered.sv
// Top level of the 3x3 Laplacian sharpen filter: configuration registers, position
// counters, line stores, window and sharpen datapath. Depends on shp_pkg, shp_line_mem
// and shp_out_seq.
//
// Pixels enter in raster order on the slave stream; tuser marks row 0, column 0. The
// input at (r,c) completes the neighborhood of (r-1,c-1), which leaves via the item and
// result registers. With the output ready, one item is accepted every cycle as long as
// each item yields at most one result; items in the last column or the last row also
// release border zeros, two to four results in all, which leave one per cycle on the
// single output port while the input stalls. Every result carries its row and column,
// tlast marks the final result of an item and tuser the bottom-right pixel of a frame.
// Line store entries are not cleared after reset, so the first full frame after reset
// must start with a start-of-frame item. Configuration may only be written while idle.
`default_nettype none
module sharpen_3x3_line_buffered (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [shp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [shp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: pixel_ch0, pixel_ch1, pixel_ch2 (lowest bit up)
  input  wire logic [shp_pkg::PIX_W-1:0]         s_axis_tdata,
  input  wire logic                              s_axis_tuser,   // start_of_frame
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata: out_row, out_col, out_ch0, out_ch1, out_ch2, zero fill (lowest bit up)
  output logic      [shp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                                   m_axis_tlast,   // last_of_input
  output logic                                   m_axis_tuser    // end_of_frame
);
  import shp_pkg::*;

  logic              color_mode_q;
  logic [WCFG_W-1:0] width_q;
  logic [HCFG_W-1:0] height_q;
  logic [WCFG_W-1:0] w_eff;
  logic [HCFG_W-1:0] h_eff;

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  c_in;
  logic [ROW_W-1:0]  r_in;
  logic [WCFG_W-1:0] col_inc;
  logic [HCFG_W-1:0] row_inc;
  logic [KIND_N-1:0] kinds_in;
  logic              accept;

  logic              a_valid_q;
  logic [PIX_W-1:0]  a_px_q;
  logic [COL_W-1:0]  a_col_q;
  logic [ROW_W-1:0]  a_row_q;
  logic [KIND_N-1:0] a_kinds_q;
  logic              a_inner_q;
  logic              a_fire;
  logic              seq_free;

  logic [PIX_W-1:0]  up_rd;
  logic [PIX_W-1:0]  mid_rd;
  logic [PIX_W-1:0]  win1_q, win3_q, win4_q, win5_q;
  logic [PIX_W-1:0]  center;
  res_t              res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= 1'b1;
      width_q      <= WIDTH_RESET;
      height_q     <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COLOR_MODE:   color_mode_q <= cfg_data_i[0];
        CFG_IMAGE_WIDTH:  width_q      <= cfg_data_i[WCFG_W-1:0];
        CFG_IMAGE_HEIGHT: height_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = width_q;
    if (width_q < WIDTH_MIN) begin
      w_eff = WIDTH_MIN;
    end else if (width_q > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end
    h_eff = height_q;
    if (height_q < HEIGHT_MIN) begin
      h_eff = HEIGHT_MIN;
    end else if (height_q > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end
  end

  // Position of the arriving item and the kinds of result it releases.
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign c_in    = s_axis_tuser ? '0 : col_q;
  assign r_in    = s_axis_tuser ? '0 : row_q;
  assign col_inc = {1'b0, c_in} + WCFG_W'(1);
  assign row_inc = {1'b0, r_in} + HCFG_W'(1);

  always_comb begin
    kinds_in              = '0;
    kinds_in[KIND_CENTER] = (r_in != '0) && (c_in != '0);
    kinds_in[KIND_RIGHT]  = (r_in != '0) && ({1'b0, c_in} == w_eff - WCFG_W'(1));
    kinds_in[KIND_BOTTOM] = ({1'b0, r_in} == h_eff - HCFG_W'(1)) && (c_in != '0);
    kinds_in[KIND_CORNER] = ({1'b0, r_in} == h_eff - HCFG_W'(1))
                            && ({1'b0, c_in} == w_eff - WCFG_W'(1));
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_d = col_inc[COL_W-1:0];
        row_d = r_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (a_fire) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_px_q    <= s_axis_tdata;
      a_col_q   <= c_in;
      a_row_q   <= r_in;
      a_kinds_q <= kinds_in;
      a_inner_q <= (r_in > ROW_W'(1)) && (c_in > COL_W'(1));
    end
  end

  assign a_fire        = a_valid_q && seq_free;
  assign s_axis_tready = !a_valid_q || seq_free;

  shp_line_mem u_upper (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (c_in),
    .rd_data_o (up_rd),
    .wr_en_i   (a_fire),
    .wr_addr_i (a_col_q),
    .wr_data_i (mid_rd)
  );

  shp_line_mem u_middle (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (c_in),
    .rd_data_o (mid_rd),
    .wr_en_i   (a_fire),
    .wr_addr_i (a_col_q),
    .wr_data_i (a_px_q)
  );

  // Window: win4 is the center, win3 above, win5 below, win1 to the left; the line
  // store read of the middle row is the right neighbor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win1_q <= '0;
      win3_q <= '0;
      win4_q <= '0;
      win5_q <= '0;
    end else if (a_fire) begin
      win1_q <= win4_q;
      win3_q <= up_rd;
      win4_q <= mid_rd;
      win5_q <= a_px_q;
    end
  end

  always_comb begin
    center = '0;
    for (int k = 0; k < 3; k++) begin
      center[k*CH_W +: CH_W] = sharpen_ch(win4_q[k*CH_W +: CH_W], win3_q[k*CH_W +: CH_W],
                                          win5_q[k*CH_W +: CH_W], win1_q[k*CH_W +: CH_W],
                                          mid_rd[k*CH_W +: CH_W]);
    end
    if (!a_inner_q) begin
      center = '0;
    end
    if (!color_mode_q) begin
      center[PIX_W-1:CH_W] = '0;
    end
  end

  always_comb begin
    res.kinds = a_kinds_q;
    res.row   = a_row_q;
    res.col   = a_col_q;
    res.pix   = center;
  end

  shp_out_seq u_out_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (a_fire),
    .res_i         (res),
    .free_o        (seq_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

`ifndef ASSERT_OFF
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !a_fire |=> a_valid_q && $stable(a_col_q) && $stable(a_kinds_q))
    else $error("waiting item was lost or changed");

  a_fire_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && a_valid_q |-> a_fire)
    else $error("item accepted over a waiting item");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q |-> {1'b0, a_col_q} < WIDTH_MAX)
    else $error("column position out of range");
`endif

endmodule
`default_nettype wire

FILE: rtl/shp_line_mem.sv
// One line store of the sharpen filter: a single-port-write, single-port-read memory.
// Read data is registered and a same-address write in the same cycle is forwarded.
`default_nettype none
module shp_line_mem (
  input  wire logic                      clk_i,
  input  wire logic                      rd_en_i,
  input  wire logic [shp_pkg::COL_W-1:0] rd_addr_i,
  output logic      [shp_pkg::PIX_W-1:0] rd_data_o,
  input  wire logic                      wr_en_i,
  input  wire logic [shp_pkg::COL_W-1:0] wr_addr_i,
  input  wire logic [shp_pkg::PIX_W-1:0] wr_data_i
);
  import shp_pkg::*;

  logic [PIX_W-1:0] mem_q [MAX_WIDTH];
  logic [PIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

FILE: rtl/shp_out_seq.sv
// Result sequencer of the sharpen filter: holds the results of one item and sends them
// one per cycle while the output is ready. Depends on shp_pkg.
`default_nettype none
module shp_out_seq (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            load_i,
  input  wire shp_pkg::res_t                   res_i,
  output logic                                 free_o,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata: out_row, out_col, out_ch0, out_ch1, out_ch2, zero fill (lowest bit up)
  output logic      [shp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                                 m_axis_tlast,   // last_of_input
  output logic                                 m_axis_tuser    // end_of_frame
);
  import shp_pkg::*;

  logic [KIND_N-1:0] kinds_q, kinds_d;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [PIX_W-1:0]  pix_q;
  logic [KIND_N-1:0] sel;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;
  logic [PIX_W-1:0]  out_pix;
  logic              done;

  // Lowest pending kind goes first.
  assign sel  = kinds_q & (~kinds_q + KIND_N'(1));
  assign done = m_axis_tvalid && m_axis_tready;

  assign m_axis_tvalid = |kinds_q;
  assign free_o        = (kinds_q == '0) || ($onehot(kinds_q) && m_axis_tready);

  always_comb begin
    out_row = row_q;
    out_col = col_q;
    out_pix = '0;
    if (sel[KIND_CENTER]) begin
      out_row = row_q - ROW_W'(1);
      out_col = col_q - COL_W'(1);
      out_pix = pix_q;
    end else if (sel[KIND_RIGHT]) begin
      out_row = row_q - ROW_W'(1);
    end else if (sel[KIND_BOTTOM]) begin
      out_col = col_q - COL_W'(1);
    end
  end

  assign m_axis_tdata = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_pix, out_col, out_row};
  assign m_axis_tlast = (kinds_q & ~sel) == '0;
  assign m_axis_tuser = sel[KIND_CORNER];

  always_comb begin
    kinds_d = kinds_q;
    if (load_i) begin
      kinds_d = res_i.kinds;
    end else if (done) begin
      kinds_d = kinds_q & ~sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kinds_q <= '0;
    end else begin
      kinds_q <= kinds_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      row_q <= res_i.row;
      col_q <= res_i.col;
      pix_q <= res_i.pix;
    end
  end

`ifndef ASSERT_OFF
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(kinds_q) && $stable(pix_q))
    else $error("pending results changed while the output was stalled");

  a_eof_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("end of frame result is not the last result of its item");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (kinds_q == '0) || ($onehot(kinds_q) && m_axis_tready))
    else $error("new item loaded over pending results");
`endif

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for sharpen_3x3_line_buffered: a short directed table, then random frames,
// each result checked against a behavioral filter model or a typed table value.
// Depends on shp_pkg and the RTL under rtl/.
module tb_top;
  import shp_pkg::*;

  localparam int SIDE_SEND      = 0;
  localparam int SIDE_RECV      = 1;
  localparam int DRAIN_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 100;
  localparam int RANDOM_ITEMS   = 286;

  typedef enum int { STEP_CFG, STEP_PIX } step_kind_e;
  typedef enum int { EXP_MODEL, EXP_NONE, EXP_ONE } exp_mode_e;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [CH_W-1:0]  ch0;
    logic [CH_W-1:0]  ch1;
    logic [CH_W-1:0]  ch2;
    logic             last;
    logic             eof;
  } px_result_t;

  typedef struct {
    step_kind_e            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [PIX_W-1:0]      px;
    logic                  sof;
    exp_mode_e             mode;
    px_result_t            typed;
  } dir_step_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIX_W-1:0]       s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tuser;

  sharpen_3x3_line_buffered u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Filter model state: line stores, window, position and register copies.
  logic [PIX_W-1:0] line_up  [MAX_WIDTH];
  logic [PIX_W-1:0] line_mid [MAX_WIDTH];
  logic [PIX_W-1:0] win      [6];
  int unsigned      pos_row;
  int unsigned      pos_col;
  logic             mdl_color;
  int unsigned      mdl_width;
  int unsigned      mdl_height;

  px_result_t expected_pixels[$];
  px_result_t no_typed;
  dir_step_t  directed[$];
  bit         any_fail    = 1'b0;
  int         results_seen = 0;
  bit         hold_done   = 1'b0;
  int         burst_left[2] = '{0, 0};

  function automatic int unsigned eff_width();
    if (mdl_width < WIDTH_MIN) return 32'(WIDTH_MIN);
    if (mdl_width > WIDTH_MAX) return 32'(WIDTH_MAX);
    return mdl_width;
  endfunction

  function automatic int unsigned eff_height();
    if (mdl_height < HEIGHT_MIN) return 32'(HEIGHT_MIN);
    if (mdl_height > HEIGHT_MAX) return 32'(HEIGHT_MAX);
    return mdl_height;
  endfunction

  function automatic logic [CH_W-1:0] sharpen_sample(input logic [CH_W-1:0] c,
                                                     input logic [CH_W-1:0] u,
                                                     input logic [CH_W-1:0] d,
                                                     input logic [CH_W-1:0] l,
                                                     input logic [CH_W-1:0] r);
    int v;
    v = 5 * int'(c) - int'(u) - int'(d) - int'(l) - int'(r);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[CH_W-1:0];
  endfunction

  function automatic px_result_t make_res(input int unsigned r, input int unsigned c,
                                          input logic [PIX_W-1:0] px, input logic eof);
    px_result_t res;
    res.row  = r[ROW_W-1:0];
    res.col  = c[COL_W-1:0];
    res.ch0  = px[0 +: CH_W];
    res.ch1  = mdl_color ? px[CH_W +: CH_W] : '0;
    res.ch2  = mdl_color ? px[2*CH_W +: CH_W] : '0;
    res.last = 1'b0;
    res.eof  = eof;
    return res;
  endfunction

  // Advances the model by one pixel; the results go to the store when keep is set.
  function automatic int predict_sharpen(input logic [PIX_W-1:0] px, input logic sof,
                                         input bit keep);
    int unsigned      w, h, r, c;
    logic [PIX_W-1:0] up, mid, center;
    px_result_t       got[4];
    int               n;
    w = eff_width();
    h = eff_height();
    n = 0;
    if (sof) begin
      pos_row = 0;
      pos_col = 0;
    end
    r = pos_row;
    c = pos_col;
    up  = line_up[c];
    mid = line_mid[c];
    line_up[c]  = mid;
    line_mid[c] = px;
    if (r >= 1 && c >= 1) begin
      center = '0;
      if (r >= 2 && c >= 2) begin
        for (int k = 0; k < 3; k++) begin
          center[CH_W*k +: CH_W] = sharpen_sample(win[4][CH_W*k +: CH_W],
                                                  win[3][CH_W*k +: CH_W],
                                                  win[5][CH_W*k +: CH_W],
                                                  win[1][CH_W*k +: CH_W],
                                                  mid[CH_W*k +: CH_W]);
        end
      end
      got[n] = make_res(r - 1, c - 1, center, 1'b0);
      n++;
    end
    if (r >= 1 && c == w - 1) begin
      got[n] = make_res(r - 1, c, '0, 1'b0);
      n++;
    end
    if (r == h - 1 && c >= 1) begin
      got[n] = make_res(r, c - 1, '0, 1'b0);
      n++;
    end
    if (r == h - 1 && c == w - 1) begin
      got[n] = make_res(r, c, '0, 1'b1);
      n++;
    end
    if (n > 0) got[n-1].last = 1'b1;
    if (keep) begin
      for (int i = 0; i < n; i++) expected_pixels.push_back(got[i]);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = up;
    win[4] = mid;
    win[5] = px;
    if (c + 1 >= w) begin
      pos_col = 0;
      pos_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
    end
    return n;
  endfunction

  // Idle cycles before the next item on one side, with occasional back-to-back stretches.
  function int pace_gap(input int side);
    if (burst_left[side] > 0) begin
      burst_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] px;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 5))
        0:       px[CH_W*k +: CH_W] = '0;
        1:       px[CH_W*k +: CH_W] = '1;
        default: px[CH_W*k +: CH_W] = CH_W'($urandom_range(0, 255));
      endcase
    end
    return px;
  endfunction

  function automatic dir_step_t cfg_step(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    dir_step_t s;
    s.kind = STEP_CFG;
    s.idx  = idx;
    s.data = data;
    s.px   = '0;
    s.sof  = 1'b0;
    s.mode = EXP_NONE;
    return s;
  endfunction

  function automatic dir_step_t pix_step(input logic [CH_W-1:0] c0, input logic [CH_W-1:0] c1,
                                         input logic [CH_W-1:0] c2, input logic sof,
                                         input exp_mode_e mode, input int unsigned r = 0,
                                         input int unsigned c = 0);
    dir_step_t s;
    s.kind       = STEP_PIX;
    s.idx        = '0;
    s.data       = '0;
    s.px         = {c2, c1, c0};
    s.sof        = sof;
    s.mode       = mode;
    s.typed.row  = r[ROW_W-1:0];
    s.typed.col  = c[COL_W-1:0];
    s.typed.ch0  = '0;
    s.typed.ch1  = '0;
    s.typed.ch2  = '0;
    s.typed.last = 1'b1;
    s.typed.eof  = 1'b0;
    return s;
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic sof, input exp_mode_e mode,
                            input px_result_t typed);
    int gap;
    gap = pace_gap(SIDE_SEND);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= px;
    s_axis_tuser  <= sof;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    void'(predict_sharpen(px, sof, mode == EXP_MODEL));
    if (mode == EXP_ONE) expected_pixels.push_back(typed);
  endtask

  // Register writes wait until the filter has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_COLOR_MODE:   mdl_color  = data[0];
      CFG_IMAGE_WIDTH:  mdl_width  = 32'(data[WCFG_W-1:0]);
      CFG_IMAGE_HEIGHT: mdl_height = 32'(data[HCFG_W-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      any_fail = 1'b1;
    end
  endtask

  task automatic check_result();
    px_result_t want;
    px_result_t got;
    got.row  = m_axis_tdata[0 +: ROW_W];
    got.col  = m_axis_tdata[ROW_W +: COL_W];
    got.ch0  = m_axis_tdata[ROW_W+COL_W +: CH_W];
    got.ch1  = m_axis_tdata[ROW_W+COL_W+CH_W +: CH_W];
    got.ch2  = m_axis_tdata[ROW_W+COL_W+2*CH_W +: CH_W];
    got.last = m_axis_tlast;
    got.eof  = m_axis_tuser;
    results_seen++;
    if (expected_pixels.size() == 0) begin
      $display("%0t ns: unexpected result at row %0d col %0d, expected none, actual ch0 %0d",
               $time, got.row, got.col, got.ch0);
      any_fail = 1'b1;
    end else begin
      want = expected_pixels.pop_front();
      compare_field("out_row", 32'(want.row), 32'(got.row));
      compare_field("out_col", 32'(want.col), 32'(got.col));
      compare_field("out_ch0", 32'(want.ch0), 32'(got.ch0));
      compare_field("out_ch1", 32'(want.ch1), 32'(got.ch1));
      compare_field("out_ch2", 32'(want.ch2), 32'(got.ch2));
      compare_field("last_of_input", 32'(want.last), 32'(got.last));
      compare_field("end_of_frame", 32'(want.eof), 32'(got.eof));
      compare_field("tdata fill", '0, 32'(m_axis_tdata >> OUT_FIELDS_W));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
  end

  // Result side: random stalls, plus one long hold-off while pixels keep coming.
  initial begin : result_sink
    int gap;
    wait (rst_ni);
    forever begin
      gap = pace_gap(SIDE_RECV);
      @(negedge clk_i);
      if (!hold_done && results_seen >= HOLD_AFTER && s_axis_tvalid) begin
        hold_done = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : run_limit
    #30_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int          rand_sent;
    int          run;
    int unsigned old_w;
    logic [2:0]  pick;
    logic        sof;
    bit          need_sof;

    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_up[i]  = '0;
      line_mid[i] = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;
    pos_row    = 0;
    pos_col    = 0;
    mdl_color  = 1'b1;
    mdl_width  = 32'(WIDTH_RESET);
    mdl_height = 32'(HEIGHT_RESET);

    // Sizes below the minimum clamp to 3x3.
    directed.push_back(cfg_step(CFG_IMAGE_WIDTH, CFG_DATA_W'(0)));
    directed.push_back(cfg_step(CFG_IMAGE_HEIGHT, CFG_DATA_W'(2)));
    directed.push_back(cfg_step(CFG_COLOR_MODE, CFG_DATA_W'(1)));
    // Color frame: the center saturates high on ch0, low on ch1 and lands at 200 on ch2.
    directed.push_back(pix_step(8'hFF, 8'h00, 8'hFF, 1'b1, EXP_NONE));
    directed.push_back(pix_step(8'h00, 8'hFF, 8'd10, 1'b0, EXP_NONE));
    directed.push_back(pix_step(8'hFF, 8'hFF, 8'hFF, 1'b0, EXP_NONE));
    directed.push_back(pix_step(8'h00, 8'hFF, 8'd30, 1'b0, EXP_NONE));
    directed.push_back(pix_step(8'hFF, 8'h00, 8'd60, 1'b0, EXP_ONE, 0, 0));
    directed.push_back(pix_step(8'h00, 8'hFF, 8'd40, 1'b0, EXP_MODEL));
    directed.push_back(pix_step(8'd128, 8'd64, 8'd32, 1'b0, EXP_NONE));
    directed.push_back(pix_step(8'h00, 8'hFF, 8'd20, 1'b0, EXP_MODEL));
    directed.push_back(pix_step(8'd7, 8'd200, 8'd99, 1'b0, EXP_MODEL));
    // The counters wrap into the next frame without a start-of-frame flag.
    directed.push_back(pix_step(8'd1, 8'd2, 8'd3, 1'b0, EXP_NONE));
    directed.push_back(pix_step(8'd4, 8'd5, 8'd6, 1'b0, EXP_NONE));
    directed.push_back(pix_step(8'd7, 8'd8, 8'd9, 1'b0, EXP_NONE));
    directed.push_back(cfg_step(CFG_COLOR_MODE, CFG_DATA_W'(0)));
    // Gray frame restarted mid-frame by the flag; ch1 and ch2 must come out as zero.
    directed.push_back(pix_step(8'h00, 8'h00, 8'h00, 1'b1, EXP_NONE));
    directed.push_back(pix_step(8'd40, 8'hFF, 8'hFF, 1'b0, EXP_NONE));
    directed.push_back(pix_step(8'h00, 8'h00, 8'h00, 1'b0, EXP_NONE));
    directed.push_back(pix_step(8'd10, 8'hFF, 8'hFF, 1'b0, EXP_NONE));
    directed.push_back(pix_step(8'd50, 8'hFF, 8'hFF, 1'b0, EXP_ONE, 0, 0));
    directed.push_back(pix_step(8'h00, 8'hFF, 8'hFF, 1'b0, EXP_MODEL));
    directed.push_back(pix_step(8'h00, 8'h00, 8'h00, 1'b0, EXP_NONE));
    directed.push_back(pix_step(8'h00, 8'hFF, 8'hFF, 1'b0, EXP_MODEL));
    directed.push_back(pix_step(8'hFF, 8'hFF, 8'hFF, 1'b0, EXP_MODEL));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == STEP_CFG) begin
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_pixel(directed[i].px, directed[i].sof, directed[i].mode, directed[i].typed);
      end
    end

    // Random frames of small sizes. A wider image is only taken on at a frame start, so
    // no line store entry is read before this frame wrote it.
    rand_sent = 0;
    need_sof  = 1'b0;
    while (rand_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        pick = 3'($urandom_range(1, 7));
        if (pick[0]) write_reg(CFG_COLOR_MODE, CFG_DATA_W'($urandom_range(0, 1)));
        if (pick[1]) begin
          old_w = eff_width();
          write_reg(CFG_IMAGE_WIDTH, {2'($urandom_range(0, 3)), 11'($urandom_range(0, 9))});
          if (eff_width() > old_w && (pos_row != 0 || pos_col != 0)) need_sof = 1'b1;
        end
        if (pick[2]) write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 7)));
      end
      run = $urandom_range(1, 2 * eff_width() * eff_height());
      for (int i = 0; i < run && rand_sent < RANDOM_ITEMS; i++) begin
        sof = need_sof || (i == 0 && $urandom_range(0, 3) == 0) || $urandom_range(0, 63) == 0;
        need_sof = 1'b0;
        send_pixel(rand_pixel(), sof, EXP_MODEL, no_typed);
        rand_sent++;
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (!any_fail) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
